@@ rtl/rn48_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn48_pkg
// Shared types and constants for the radix node48 child table: operation
// and status codes, controller states and the memory control bundle.
// ----------------------------------------------------------------------------
package rn48_pkg;

  localparam int SLOT_COUNT_DEF = 48;
  localparam int KEY_SPACE_DEF  = 256;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 8;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;

  localparam logic [CFG_W-1:0] SHRINK_RST = CFG_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_CHANGE = 3'd3,
    OP_NEXT   = 3'd4,
    OP_PREV   = 3'd5,
    OP_FIRST  = 3'd6,
    OP_LAST   = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_SHRINK = 2'd2,
    STS_ABSENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_MAP,
    S_VAL,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic map_rd;
    logic map_wr;
    logic val_rd;
    logic val_wr;
  } mem_ctl_t;

endpackage

@@ rtl/rn48_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn48_search
// Priority encoders over the key presence bitmap (lookup, next, prev, first,
// last) and over the slot usage bitmap (lowest free slot).
// ----------------------------------------------------------------------------
module rn48_search #(
  parameter int KEY_SPACE  = rn48_pkg::KEY_SPACE_DEF,
  parameter int SLOT_COUNT = rn48_pkg::SLOT_COUNT_DEF,
  localparam int KEY_IDX_W  = $clog2(KEY_SPACE),
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT)
) (
  input  rn48_pkg::op_t                op,
  input  logic [rn48_pkg::KEY_W-1:0]   key,
  input  logic [KEY_SPACE-1:0]         present,
  input  logic [SLOT_COUNT-1:0]        used,
  output logic                         hit_ok,
  output logic [KEY_IDX_W-1:0]         hit_idx,
  output logic                         free_ok,
  output logic [SLOT_IDX_W-1:0]        free_idx
);
  import rn48_pkg::*;

  logic [KEY_W:0]          key_x;
  logic [KEY_SPACE-1:0]    mask;
  logic [KEY_SPACE-1:0]    cand;
  logic [KEY_IDX_W-1:0]    lo_idx;
  logic [KEY_IDX_W-1:0]    hi_idx;

  assign key_x = {1'b0, key};

  // Window of keys each operation may hit; plain lookups hit the key itself.
  always_comb begin
    for (int i = 0; i < KEY_SPACE; i++) begin
      case (op)
        OP_NEXT:           mask[i] = ((KEY_W+1)'(i) >= key_x);
        OP_PREV:           mask[i] = ((KEY_W+1)'(i) <  key_x);
        OP_FIRST, OP_LAST: mask[i] = 1'b1;
        default:           mask[i] = ((KEY_W+1)'(i) == key_x);
      endcase
    end
  end

  assign cand   = mask & present;
  assign hit_ok = |cand;

  always_comb begin
    lo_idx = '0;
    for (int i = KEY_SPACE - 1; i >= 0; i--) begin
      if (cand[i]) lo_idx = KEY_IDX_W'(i);
    end
  end

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < KEY_SPACE; i++) begin
      if (cand[i]) hi_idx = KEY_IDX_W'(i);
    end
  end

  assign hit_idx = (op == OP_PREV || op == OP_LAST) ? hi_idx : lo_idx;

  assign free_ok = ~&used;

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) free_idx = SLOT_IDX_W'(i);
    end
  end

endmodule

@@ rtl/rn48_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn48_store
// Key-to-slot map memory and slot value memory, one port each, with a
// registered read.
// ----------------------------------------------------------------------------
module rn48_store #(
  parameter int KEY_SPACE  = rn48_pkg::KEY_SPACE_DEF,
  parameter int SLOT_COUNT = rn48_pkg::SLOT_COUNT_DEF,
  localparam int KEY_IDX_W  = $clog2(KEY_SPACE),
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                        clk,
  input  rn48_pkg::mem_ctl_t          ctl,
  input  logic [KEY_IDX_W-1:0]        map_addr,
  input  logic [SLOT_IDX_W-1:0]       map_wdata,
  output logic [SLOT_IDX_W-1:0]       map_rdata,
  input  logic [SLOT_IDX_W-1:0]       val_addr,
  input  logic [rn48_pkg::VAL_W-1:0]  val_wdata,
  output logic [rn48_pkg::VAL_W-1:0]  val_rdata
);
  import rn48_pkg::*;

  logic [SLOT_IDX_W-1:0] map_mem [KEY_SPACE];
  logic [VAL_W-1:0]      val_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.map_wr) map_mem[map_addr] <= map_wdata;
    if (ctl.map_rd) map_rdata <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.val_wr) val_mem[val_addr] <= val_wdata;
    if (ctl.val_rd) val_rdata <= val_mem[val_addr];
  end

endmodule

@@ rtl/radix_node48_child_table.sv @@
`timescale 1ns / 1ps
// Flow: an item passes search, then done; items settled by the bitmaps
//   alone go straight to done, writes through the slot map pass the map
//   state first, lookups and searches the map, then the value state.
// One item at a time: a new item is taken only in the idle state, after
//   the last one has left the done state and handed on its result.
// Reset: synchronous, active low; clears presence and usage bitmaps, the
//   entry count and the handshake state, and loads shrink threshold 16.
// ----------------------------------------------------------------------------
// radix_node48_child_table
// Sparse 256-key child table with 48 value slots: insert, remove, lookup,
// change and ordered searches over the present keys.
// ----------------------------------------------------------------------------
module radix_node48_child_table #(
  parameter int KEY_SPACE  = rn48_pkg::KEY_SPACE_DEF,
  parameter int SLOT_COUNT = rn48_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rn48_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rn48_pkg::OP_W-1:0]      in_operation,
  input  logic [rn48_pkg::KEY_W-1:0]     in_key_byte,
  input  logic [rn48_pkg::VAL_W-1:0]     in_child_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rn48_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_found,
  output logic [rn48_pkg::VAL_W-1:0]     out_result_value
);
  import rn48_pkg::*;

  localparam int KEY_IDX_W  = $clog2(KEY_SPACE);
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  fsm_state_t              state_r, state_nxt;
  op_t                     op_r;
  logic [KEY_W-1:0]        key_r;
  logic [VAL_W-1:0]        val_r;
  logic [CFG_W-1:0]        thr_r;
  logic [KEY_SPACE-1:0]    pres_r, pres_nxt;
  logic [SLOT_COUNT-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [VAL_W-1:0]        res_value_r, res_value_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [VAL_W-1:0]        out_value_r, out_value_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    in_range;
  logic                    is_query;
  logic [KEY_IDX_W-1:0]    key_idx;
  logic                    hit_ok;
  logic [KEY_IDX_W-1:0]    hit_idx;
  logic                    free_ok;
  logic [SLOT_IDX_W-1:0]   free_idx;
  logic                    srch_map;
  logic                    ins_new;
  status_t                 srch_sts;

  mem_ctl_t                mem_ctl;
  logic [KEY_IDX_W-1:0]    map_addr;
  logic [SLOT_IDX_W-1:0]   map_q;
  logic [SLOT_IDX_W-1:0]   val_addr;
  logic [VAL_W-1:0]        val_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign in_range = ({1'b0, key_r} < (KEY_W+1)'(KEY_SPACE));
  assign key_idx  = key_r[KEY_IDX_W-1:0];
  assign is_query = (op_r == OP_LOOKUP) || (op_r == OP_NEXT) || (op_r == OP_PREV)
                 || (op_r == OP_FIRST) || (op_r == OP_LAST);

  rn48_search #(
    .KEY_SPACE  (KEY_SPACE),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_search (
    .op       (op_r),
    .key      (key_r),
    .present  (pres_r),
    .used     (used_r),
    .hit_ok   (hit_ok),
    .hit_idx  (hit_idx),
    .free_ok  (free_ok),
    .free_idx (free_idx)
  );

  rn48_store #(
    .KEY_SPACE  (KEY_SPACE),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .map_addr  (map_addr),
    .map_wdata (free_idx),
    .map_rdata (map_q),
    .val_addr  (val_addr),
    .val_wdata (val_r),
    .val_rdata (val_q)
  );

  // Decide the item from the bitmaps; for non-query ops hit_ok is presence.
  always_comb begin
    srch_map = 1'b0;
    ins_new  = 1'b0;
    srch_sts = STS_OK;
    unique case (op_r)
      OP_INSERT: begin
        if (!in_range) begin
          srch_sts = STS_ABSENT;
        end else if (hit_ok) begin
          srch_map = 1'b1;
        end else if (count_r >= CNT_W'(SLOT_COUNT) || !free_ok) begin
          srch_sts = STS_FULL;
        end else begin
          ins_new = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!hit_ok) begin
          srch_sts = STS_ABSENT;
        end else if (CMP_W'(count_r) == CMP_W'(thr_r)) begin
          srch_sts = STS_SHRINK;
        end else begin
          srch_map = 1'b1;
        end
      end
      default: begin
        if (hit_ok) begin
          srch_map = 1'b1;
        end else begin
          srch_sts = STS_ABSENT;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SRCH;
      S_SRCH: state_nxt = srch_map ? S_MAP : S_DONE;
      S_MAP:  state_nxt = is_query ? S_VAL : S_DONE;
      S_VAL:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl        = '0;
    map_addr       = ins_new ? key_idx : hit_idx;
    val_addr       = free_idx;
    pres_nxt       = pres_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    unique case (state_r)
      S_IDLE: begin
        res_status_nxt = STS_OK;
        res_found_nxt  = 1'b0;
        res_value_nxt  = '0;
      end
      S_SRCH: begin
        res_status_nxt = srch_sts;
        mem_ctl.map_rd = srch_map;
        if (ins_new) begin
          mem_ctl.map_wr     = 1'b1;
          mem_ctl.val_wr     = 1'b1;
          pres_nxt[key_idx]  = 1'b1;
          used_nxt[free_idx] = 1'b1;
          count_nxt          = count_r + CNT_W'(1);
        end
      end
      S_MAP: begin
        val_addr = map_q;
        case (op_r)
          OP_INSERT, OP_CHANGE: mem_ctl.val_wr = 1'b1;
          OP_REMOVE: begin
            // free the slot and drop the key
            used_nxt[map_q]   = 1'b0;
            pres_nxt[key_idx] = 1'b0;
            if (count_r != '0) count_nxt = count_r - CNT_W'(1);
          end
          default: mem_ctl.val_rd = 1'b1;
        endcase
      end
      S_VAL: begin
        res_found_nxt = 1'b1;
        res_value_nxt = val_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_value_nxt  = res_value_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= SHRINK_RST;
      pres_r      <= '0;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pres_r      <= pres_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_operation);
      key_r <= in_key_byte;
      val_r <= in_child_value;
    end
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("entry count above slot count");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == count_r)
    else $error("slot usage bitmap disagrees with entry count");

  a_pres_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pres_r) == count_r)
    else $error("key presence bitmap disagrees with entry count");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

endmodule

@@ tb/sv/radix_node48_child_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_node48_child_table_tb
// Self-checking bench for the 48-slot child table. A driver and a monitor,
// both clocked, move items with random idle bursts on each side. A
// behavioral copy of the table predicts one result for every accepted
// item, and the monitor compares each result, field by field, against it.
// Several shrink thresholds are used, and they are changed only between
// phases, while the table is drained.
// ----------------------------------------------------------------------------
module radix_node48_child_table_tb;
  import rn48_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } table_cmd_t;

  typedef struct {
    status_t          status;
    logic             found;
    logic [VAL_W-1:0] value;
  } table_answer_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [KEY_W-1:0]    in_key_byte = '0;
  logic [VAL_W-1:0]    in_child_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [VAL_W-1:0]    out_result_value;

  radix_node48_child_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_key_byte      (in_key_byte),
    .in_child_value   (in_child_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_result_value (out_result_value)
  );

  // Shadow copy of the table
  logic             key_live [KEY_SPACE_DEF];
  logic [5:0]       key_slot [KEY_SPACE_DEF];
  logic [VAL_W-1:0] slot_word [SLOT_COUNT_DEF];
  logic             slot_taken [SLOT_COUNT_DEF];
  int               entry_total;
  logic [CFG_W-1:0] shrink_at;

  table_cmd_t    pending_cmds [$];
  table_answer_t answers_due [$];
  logic [KEY_W-1:0] key_pool [$];

  int  errors = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  bit  calm = 1'b0;
  int  in_hold = 0;
  int  out_hold = 0;
  int  quiet_cycles = 0;
  table_answer_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int nearest_up(int lo);
    for (int i = lo; i < KEY_SPACE_DEF; i++)
      if (key_live[i]) return i;
    return -1;
  endfunction

  // Highest present key strictly below the bound
  function automatic int nearest_below(int bound);
    for (int i = bound - 1; i >= 0; i--)
      if (key_live[i]) return i;
    return -1;
  endfunction

  function automatic table_answer_t table_step(op_t op, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] val);
    table_answer_t ans;
    int hit;
    int s;
    ans.status = STS_OK;
    ans.found  = 1'b0;
    ans.value  = '0;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (key_live[key]) begin
          slot_word[key_slot[key]] = val;
        end else if (entry_total >= SLOT_COUNT_DEF) begin
          ans.status = STS_FULL;
        end else begin
          s = 0;
          while (s < SLOT_COUNT_DEF && slot_taken[s]) s++;
          slot_taken[s] = 1'b1;
          slot_word[s]  = val;
          key_slot[key] = 6'(s);
          key_live[key] = 1'b1;
          entry_total++;
        end
      end
      OP_REMOVE: begin
        if (!key_live[key]) begin
          ans.status = STS_ABSENT;
        end else if (entry_total == int'(shrink_at)) begin
          ans.status = STS_SHRINK;
        end else begin
          slot_taken[key_slot[key]] = 1'b0;
          key_live[key] = 1'b0;
          entry_total--;
        end
      end
      OP_CHANGE: begin
        if (key_live[key]) slot_word[key_slot[key]] = val;
        else ans.status = STS_ABSENT;
      end
      OP_LOOKUP: hit = key_live[key] ? int'(key) : -1;
      OP_NEXT:   hit = nearest_up(int'(key));
      OP_PREV:   hit = nearest_below(int'(key));
      OP_FIRST:  hit = nearest_up(0);
      default:   hit = nearest_below(KEY_SPACE_DEF);
    endcase
    if (op == OP_LOOKUP || op >= OP_NEXT) begin
      if (hit >= 0) begin
        ans.found = 1'b1;
        ans.value = slot_word[key_slot[hit]];
      end else begin
        ans.status = STS_ABSENT;
      end
    end
    return ans;
  endfunction

  // Driver: predict on accept, then present the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && in_ready)
        answers_due.push_back(table_step(op_t'(in_operation), in_key_byte, in_child_value));
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
          in_hold = $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          table_cmd_t c;
          c = pending_cmds.pop_front();
          in_operation   <= c.op;
          in_key_byte    <= c.key;
          in_child_value <= c.val;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the oldest prediction, stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got status %0d found %0b value %h",
                   $time, out_status, out_found, out_result_value);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          end
          if (out_found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b, got %0b", $time, want.found, out_found);
          end
          if (out_result_value !== want.value) begin
            errors++;
            $display("%0t: result_value expected %h, got %h",
                     $time, want.value, out_result_value);
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_hold = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_cmd(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    table_cmd_t c;
    c.op  = op;
    c.key = key;
    c.val = val;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || answers_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_threshold(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shrink_at = v;
  endtask

  // One random phase; a pool size of zero keeps the previous key pool
  task automatic run_phase(int n, int pool_n, int ins_w, int rem_w, int in_idle,
                           int out_idle);
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    int               r;
    @(negedge clk);
    in_idle_pct  = in_idle;
    out_idle_pct = out_idle;
    if (pool_n > 0) begin
      key_pool.delete();
      repeat (pool_n) key_pool.push_back(KEY_W'($urandom));
      if ($urandom_range(0, 1)) key_pool.push_back('0);
      if ($urandom_range(0, 1)) key_pool.push_back('1);
    end
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) op = OP_INSERT;
      else if (r < ins_w + rem_w) op = OP_REMOVE;
      else op = op_t'($urandom_range(OP_LOOKUP, OP_LAST));
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      case ($urandom_range(0, 15))
        0:       val = '0;
        1:       val = '1;
        default: val = {$urandom, $urandom};
      endcase
      add_cmd(op, key, val);
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < KEY_SPACE_DEF; i++) begin
      key_live[i] = 1'b0;
      key_slot[i] = '0;
    end
    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
      slot_taken[i] = 1'b0;
      slot_word[i]  = '0;
    end
    entry_total = 0;
    shrink_at   = SHRINK_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table searches, extremes, overwrite, refusals
    set_threshold(CFG_W'(2));
    @(negedge clk);
    in_idle_pct  = 30;
    out_idle_pct = 30;
    add_cmd(OP_FIRST,  8'd0,   '0);
    add_cmd(OP_LAST,   8'd0,   '1);
    add_cmd(OP_NEXT,   8'd0,   '0);
    add_cmd(OP_PREV,   8'd255, '0);
    add_cmd(OP_LOOKUP, 8'd5,   '0);
    add_cmd(OP_REMOVE, 8'd5,   '0);
    add_cmd(OP_CHANGE, 8'd5,   64'h1234);
    add_cmd(OP_INSERT, 8'd0,   '0);
    add_cmd(OP_INSERT, 8'd255, '1);
    add_cmd(OP_INSERT, 8'd0,   64'hA5A5_5A5A_0F0F_F0F0);
    add_cmd(OP_LOOKUP, 8'd0,   '0);
    add_cmd(OP_CHANGE, 8'd255, 64'h5A5A_A5A5_F0F0_0F0F);
    add_cmd(OP_LOOKUP, 8'd255, '0);
    add_cmd(OP_NEXT,   8'd1,   '0);
    add_cmd(OP_NEXT,   8'd255, '0);
    add_cmd(OP_NEXT,   8'd0,   '0);
    add_cmd(OP_PREV,   8'd0,   '0);
    add_cmd(OP_PREV,   8'd255, '0);
    add_cmd(OP_PREV,   8'd1,   '0);
    add_cmd(OP_FIRST,  8'd77,  '0);
    add_cmd(OP_LAST,   8'd77,  '0);
    add_cmd(OP_REMOVE, 8'd0,   '0);
    add_cmd(OP_INSERT, 8'd128, 64'h8000_0000_0000_0001);
    add_cmd(OP_REMOVE, 8'd0,   '0);
    add_cmd(OP_REMOVE, 8'd0,   '0);
    add_cmd(OP_LOOKUP, 8'd0,   '0);
    wait_drained();

    // Fill past capacity; removes are refused once full
    set_threshold(CFG_W'(48));
    run_phase(200, 70, 60, 10, 20, 20);
    // Drain the same keys with the lowest threshold
    set_threshold(CFG_W'(0));
    run_phase(150, 0, 10, 60, 50, 50);
    // Hover around a random threshold
    set_threshold(CFG_W'($urandom_range(1, 47)));
    run_phase(200, 2 * int'(shrink_at) + 2, 35, 35, 25, 25);
    set_threshold(CFG_W'(63));
    run_phase(150, 120, 40, 20, 0, 0);
    set_threshold(CFG_W'(20));
    run_phase(200, 40, 40, 40, 40, 10);
    // No idling at the end
    set_threshold(CFG_W'($urandom_range(0, 48)));
    calm = 1'b1;
    run_phase(200, 60, 40, 30, 0, 0);

    repeat (20) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rn48_pkg.sv
rtl/rn48_search.sv
rtl/rn48_store.sv
rtl/radix_node48_child_table.sv
tb/sv/radix_node48_child_table_tb.sv
